FILE: rtl/tlvd_pkg.sv
`default_nettype none

package tlvd_pkg;

    // Widths of the message length, byte position and joined count, and of the config index and data.
    localparam int LengthBits = 16;
    localparam int CfgIndexBits = 2;
    localparam int CfgDataBits = 16;

    // Configuration register indexes.
    localparam logic [CfgIndexBits-1:0] CFG_TARGET_TYPE = 2'd0;
    localparam logic [CfgIndexBits-1:0] CFG_JOIN_LIMIT = 2'd1;

    // Reset values of the configuration registers.
    localparam logic [7:0] TargetTypeReset = 8'd0;
    localparam logic [LengthBits-1:0] JoinLimitReset = {LengthBits{1'b1}};

    // Header phase of the record walk.
    typedef enum logic [1:0] {
        PH_TYPE,
        PH_LEN,
        PH_VALUE,
        PH_STOP
    } t_phase;

    // Status reported with the final byte of a message.
    typedef enum logic [1:0] {
        STATUS_FOUND,
        STATUS_NOT_FOUND,
        STATUS_OVERFLOW
    } t_status;

    // One input request: a message byte and the message length.
    typedef struct packed {
        logic [7:0]            in_byte;
        logic [LengthBits-1:0] message_length;
    } t_in_item;

    // One result request.
    typedef struct packed {
        logic                  byte_valid;
        logic [7:0]            out_byte;
        logic                  done_res;
        t_status               status;
        logic [LengthBits-1:0] total_length;
    } t_out_item;

    // Configuration values handed to the decoding logic.
    typedef struct packed {
        logic [7:0]            target_type;
        logic [LengthBits-1:0] join_limit;
    } t_cfg;

endpackage

`default_nettype wire

FILE: rtl/tlvd_cfg.sv
`default_nettype none

module tlvd_cfg (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_valid,
    input  wire logic [tlvd_pkg::CfgIndexBits-1:0] i_cfg_index,
    input  wire logic [tlvd_pkg::CfgDataBits-1:0]  i_cfg_data,
    output tlvd_pkg::t_cfg                        o_cfg
);

    logic [7:0]                      r_target_type;
    logic [tlvd_pkg::LengthBits-1:0] r_join_limit;

    // Register writes; an index beyond the list is ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target_type <= tlvd_pkg::TargetTypeReset;
            r_join_limit  <= tlvd_pkg::JoinLimitReset;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                tlvd_pkg::CFG_TARGET_TYPE: begin
                    r_target_type <= i_cfg_data[7:0];
                end
                tlvd_pkg::CFG_JOIN_LIMIT: begin
                    r_join_limit <= i_cfg_data[tlvd_pkg::LengthBits-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign o_cfg.target_type = r_target_type;
    assign o_cfg.join_limit  = r_join_limit;

endmodule

`default_nettype wire

FILE: rtl/tlvd_step.sv
`default_nettype none

module tlvd_step (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_advance,
    input  wire tlvd_pkg::t_in_item i_item,
    input  wire tlvd_pkg::t_cfg     i_cfg,
    output logic                    o_has_result,
    output tlvd_pkg::t_out_item     o_result
);

    localparam int LB = tlvd_pkg::LengthBits;

    tlvd_pkg::t_phase r_phase, n_phase, u_phase;
    logic [LB-1:0]    r_pos, n_pos;
    logic [7:0]       r_rem, n_rem, u_rem;
    logic             r_match, n_match, u_match;
    logic             r_run, n_run, u_run;
    logic             r_found, n_found, u_found;
    logic             r_ovf, n_ovf, u_ovf;
    logic [LB-1:0]    r_count, n_count, u_count;

    logic [LB:0]      pos_p1;
    logic [LB:0]      pos_p2;
    logic [LB+1:0]    pos_end;
    logic [LB:0]      cnt_sum;
    logic             emit;
    logic             done;

    // Sums used by the header checks.
    assign pos_p1  = {1'b0, r_pos} + {{LB{1'b0}}, 1'b1};
    assign pos_p2  = {1'b0, r_pos} + (LB+1)'(2);
    assign pos_end = {1'b0, pos_p1} + (LB+2)'(i_item.in_byte);
    assign cnt_sum = {1'b0, r_count} + (LB+1)'(i_item.in_byte);
    assign done    = (pos_p1 >= {1'b0, i_item.message_length});
    assign emit    = (r_phase == tlvd_pkg::PH_VALUE) && r_match;

    // Next state: walk one byte through the header phases.
    always_comb begin
        u_phase = r_phase;
        u_rem   = r_rem;
        u_match = r_match;
        u_run   = r_run;
        u_found = r_found;
        u_ovf   = r_ovf;
        u_count = r_count;
        case (r_phase)
            tlvd_pkg::PH_TYPE: begin
                if (pos_p2 > {1'b0, i_item.message_length}) begin
                    u_phase = tlvd_pkg::PH_STOP;
                end else if ((i_item.in_byte != i_cfg.target_type) && r_run) begin
                    u_phase = tlvd_pkg::PH_STOP;
                end else begin
                    u_match = (i_item.in_byte == i_cfg.target_type);
                    u_phase = tlvd_pkg::PH_LEN;
                end
            end
            tlvd_pkg::PH_LEN: begin
                if (pos_end > {2'b00, i_item.message_length}) begin
                    u_phase = tlvd_pkg::PH_STOP;
                end else if (r_match && (cnt_sum > {1'b0, i_cfg.join_limit})) begin
                    u_found = 1'b1;
                    u_run   = 1'b1;
                    u_ovf   = 1'b1;
                    u_phase = tlvd_pkg::PH_STOP;
                end else begin
                    if (r_match) begin
                        u_found = 1'b1;
                        u_run   = 1'b1;
                    end
                    u_rem   = i_item.in_byte;
                    u_phase = (i_item.in_byte != 8'd0) ? tlvd_pkg::PH_VALUE
                                                       : tlvd_pkg::PH_TYPE;
                end
            end
            tlvd_pkg::PH_VALUE: begin
                if (r_match) begin
                    u_count = r_count + {{(LB-1){1'b0}}, 1'b1};
                end
                if (r_rem > 8'd1) begin
                    u_rem = r_rem - 8'd1;
                end else begin
                    u_rem   = 8'd0;
                    u_phase = tlvd_pkg::PH_TYPE;
                end
            end
            default: begin
            end
        endcase

        // The final byte clears the per-message state.
        if (done) begin
            n_phase = tlvd_pkg::PH_TYPE;
            n_pos   = '0;
            n_rem   = '0;
            n_match = 1'b0;
            n_run   = 1'b0;
            n_found = 1'b0;
            n_ovf   = 1'b0;
            n_count = '0;
        end else begin
            n_phase = u_phase;
            n_pos   = pos_p1[LB-1:0];
            n_rem   = u_rem;
            n_match = u_match;
            n_run   = u_run;
            n_found = u_found;
            n_ovf   = u_ovf;
            n_count = u_count;
        end
    end

    // Result for this byte, built from the updated flags.
    always_comb begin
        o_has_result          = emit || done;
        o_result.byte_valid   = emit;
        o_result.out_byte     = emit ? i_item.in_byte : 8'd0;
        o_result.done_res     = done;
        o_result.status       = tlvd_pkg::STATUS_FOUND;
        o_result.total_length = '0;
        if (done) begin
            if (u_ovf) begin
                o_result.status = tlvd_pkg::STATUS_OVERFLOW;
            end else if (u_found) begin
                o_result.status       = tlvd_pkg::STATUS_FOUND;
                o_result.total_length = u_count;
            end else begin
                o_result.status = tlvd_pkg::STATUS_NOT_FOUND;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= tlvd_pkg::PH_TYPE;
            r_pos   <= '0;
            r_rem   <= '0;
            r_match <= 1'b0;
            r_run   <= 1'b0;
            r_found <= 1'b0;
            r_ovf   <= 1'b0;
            r_count <= '0;
        end else if (i_advance) begin
            r_phase <= n_phase;
            r_pos   <= n_pos;
            r_rem   <= n_rem;
            r_match <= n_match;
            r_run   <= n_run;
            r_found <= n_found;
            r_ovf   <= n_ovf;
            r_count <= n_count;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/tlv8_fragment_concat_decoder.sv
`default_nettype none

// Channel   Direction  Handshake                      Payload
// in        input      i_in_valid / o_in_ready        i_in_data  (t_in_item)
// out       output     o_out_valid / i_out_ready      o_out_data (t_out_item)
// cfg       input      i_cfg_valid / o_cfg_ready      i_cfg_index, i_cfg_data
//
// One byte request is accepted per cycle unless the output stalls. A byte is
// held in the input register, decoded by the header logic and, when it emits a
// value byte or ends the message, lands in the output register. The output
// register lets the next byte in while a result waits.
// Reset is synchronous and active low; the walk restarts at a type byte.
// A stalled output holds the input register, which then holds o_in_ready low.

module tlv8_fragment_concat_decoder (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_ready,
    input  wire tlvd_pkg::t_in_item                i_in_data,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_ready,
    output tlvd_pkg::t_out_item                    o_out_data,
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [tlvd_pkg::CfgIndexBits-1:0] i_cfg_index,
    input  wire logic [tlvd_pkg::CfgDataBits-1:0]  i_cfg_data
);

    logic                r_in_valid;
    tlvd_pkg::t_in_item  r_in;
    logic                r_out_valid;
    tlvd_pkg::t_out_item r_out;
    logic                advance;
    logic                has_result;
    tlvd_pkg::t_out_item result;
    tlvd_pkg::t_cfg      cfg;

    // The held byte moves on whenever the output register is free.
    assign advance     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || advance;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    tlvd_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    tlvd_step u_step (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_advance    (advance),
        .i_item       (r_in),
        .i_cfg        (cfg),
        .o_has_result (has_result),
        .o_result     (result)
    );

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in_data;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && has_result) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && has_result) begin
            r_out <= result;
        end
    end

endmodule

`default_nettype wire

FILE: verif/tb_tlv8_fragment_concat_decoder.sv
`timescale 1ns / 1ps

module tb_tlv8_fragment_concat_decoder;

    localparam int ClockPeriod = 10;
    localparam int ResetCycles = 11;
    localparam int SettleCycles = 8;
    localparam int CycleLimit = 300000;
    localparam int PhaseBytes = 300;
    localparam int HoldCycles = 400;
    localparam int MaxReported = 10;

    // Index with no register behind it; a write there must change nothing.
    localparam logic [tlvd_pkg::CfgIndexBits-1:0] CfgSpareIndex = 2'd3;

    // Message end with nothing found, as seen on the final byte.
    localparam tlvd_pkg::t_out_item EndNotFound = '{byte_valid: 1'b0, out_byte: 8'h00,
                                                    done_res: 1'b1,
                                                    status: tlvd_pkg::STATUS_NOT_FOUND,
                                                    total_length: '0};

    // One row of the directed table: a byte request and, where it is obvious,
    // the result that it must produce.
    typedef struct packed {
        tlvd_pkg::t_in_item  req;
        logic                typed;
        tlvd_pkg::t_out_item res;
    } t_dir_row;

    logic                              i_clk = 1'b0;
    logic                              i_rst_n = 1'b0;
    logic                              i_in_valid = 1'b0;
    logic                              o_in_ready;
    tlvd_pkg::t_in_item                i_in_data = '0;
    logic                              o_out_valid;
    logic                              i_out_ready = 1'b0;
    tlvd_pkg::t_out_item               o_out_data;
    logic                              i_cfg_valid = 1'b0;
    logic                              o_cfg_ready;
    logic [tlvd_pkg::CfgIndexBits-1:0] i_cfg_index = '0;
    logic [tlvd_pkg::CfgDataBits-1:0]  i_cfg_data = '0;

    // Shadow of the configuration registers.
    logic [7:0]                      want_type = tlvd_pkg::TargetTypeReset;
    logic [tlvd_pkg::LengthBits-1:0] capacity = tlvd_pkg::JoinLimitReset;

    // Shadow of the record walk.
    tlvd_pkg::t_phase walk_phase = tlvd_pkg::PH_TYPE;
    int     walk_pos = 0;
    int     value_left = 0;
    bit     record_hit = 1'b0;
    bit     run_open = 1'b0;
    bit     found_any = 1'b0;
    bit     over_capacity = 1'b0;
    int     joined_count = 0;

    tlvd_pkg::t_out_item results_due[$];
    logic [7:0]          message_bytes[$];
    tlvd_pkg::t_in_item  message_reqs[$];
    t_dir_row            directed_table[$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_request = 0;
    int hold_left = 0;

    int unsigned cycles_run = 0;
    int unsigned mismatches = 0;
    int unsigned bytes_sent = 0;
    int unsigned cfg_writes = 0;
    int unsigned values_joined = 0;
    int unsigned ends_found = 0;
    int unsigned ends_missing = 0;
    int unsigned ends_over = 0;
    tlvd_pkg::t_out_item seen;
    tlvd_pkg::t_out_item wanted;

    tlv8_fragment_concat_decoder dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #(ClockPeriod / 2) i_clk = ~i_clk;
    end

    // Walks one message byte through the shadow state and returns 1 when the
    // byte emits a value byte or ends the message.
    function automatic bit decode_tlv_byte(input tlvd_pkg::t_in_item req,
                                           output tlvd_pkg::t_out_item res);
        int b;
        int len;
        int pos;
        bit emit;
        bit last;
        b = req.in_byte;
        len = req.message_length;
        pos = walk_pos;
        emit = 1'b0;
        case (walk_phase)
            tlvd_pkg::PH_TYPE: begin
                if (pos + 2 > len) begin
                    walk_phase = tlvd_pkg::PH_STOP;
                end else if (b != want_type && run_open) begin
                    walk_phase = tlvd_pkg::PH_STOP;
                end else begin
                    record_hit = (b == want_type);
                    walk_phase = tlvd_pkg::PH_LEN;
                end
            end
            tlvd_pkg::PH_LEN: begin
                if (pos + 1 + b > len) begin
                    walk_phase = tlvd_pkg::PH_STOP;
                end else if (record_hit && joined_count + b > capacity) begin
                    found_any = 1'b1;
                    run_open = 1'b1;
                    over_capacity = 1'b1;
                    walk_phase = tlvd_pkg::PH_STOP;
                end else begin
                    if (record_hit) begin
                        found_any = 1'b1;
                        run_open = 1'b1;
                    end
                    value_left = b;
                    walk_phase = (b != 0) ? tlvd_pkg::PH_VALUE : tlvd_pkg::PH_TYPE;
                end
            end
            tlvd_pkg::PH_VALUE: begin
                if (record_hit) begin
                    emit = 1'b1;
                    joined_count = (joined_count + 1) & 16'hFFFF;
                end
                if (value_left > 0) begin
                    value_left--;
                end
                if (value_left == 0) begin
                    walk_phase = tlvd_pkg::PH_TYPE;
                end
            end
            default: begin
            end
        endcase
        walk_pos = (pos + 1) & 16'hFFFF;
        last = (pos + 1 >= len);
        res = '0;
        if (emit) begin
            res.byte_valid = 1'b1;
            res.out_byte = req.in_byte;
        end
        if (last) begin
            res.done_res = 1'b1;
            if (over_capacity) begin
                res.status = tlvd_pkg::STATUS_OVERFLOW;
            end else if (found_any) begin
                res.status = tlvd_pkg::STATUS_FOUND;
                res.total_length = joined_count[tlvd_pkg::LengthBits-1:0];
            end else begin
                res.status = tlvd_pkg::STATUS_NOT_FOUND;
            end
            // The next byte starts a fresh message.
            walk_phase = tlvd_pkg::PH_TYPE;
            walk_pos = 0;
            value_left = 0;
            record_hit = 1'b0;
            run_open = 1'b0;
            found_any = 1'b0;
            over_capacity = 1'b0;
            joined_count = 0;
        end
        return emit || last;
    endfunction

    function automatic t_dir_row dir_row(input logic [7:0] b, input logic [15:0] len,
                                         input bit typed = 1'b0,
                                         input tlvd_pkg::t_out_item res = '0);
        t_dir_row row;
        row.req.in_byte = b;
        row.req.message_length = len;
        row.typed = typed;
        row.res = res;
        return row;
    endfunction

    function automatic void report_mismatch(input string what,
                                            input tlvd_pkg::t_out_item want,
                                            input tlvd_pkg::t_out_item got);
        mismatches++;
        if (mismatches <= MaxReported) begin
            $display("[%0t] %s: expected bv=%0b byte=%02h done=%0b status=%0d total=%0d,",
                     $time, what, want.byte_valid, want.out_byte, want.done_res,
                     want.status, want.total_length);
            $display("    got bv=%0b byte=%02h done=%0b status=%0d total=%0d",
                     got.byte_valid, got.out_byte, got.done_res, got.status,
                     got.total_length);
        end
    endfunction

    // Offers one byte request, with random idle cycles ahead of it, and files
    // the expected result once the block takes it.
    task automatic send_request(input tlvd_pkg::t_in_item req, input bit typed,
                                input tlvd_pkg::t_out_item typed_res);
        tlvd_pkg::t_out_item res;
        bit                  has_res;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= req;
        do @(posedge i_clk); while (!o_in_ready);
        has_res = decode_tlv_byte(req, res);
        if (typed) begin
            results_due.push_back(typed_res);
        end else if (has_res) begin
            results_due.push_back(res);
        end
        bytes_sent++;
    endtask

    // Valid is left high; the caller lowers it after the last write.
    task automatic write_register(input logic [tlvd_pkg::CfgIndexBits-1:0] idx,
                                  input logic [15:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == tlvd_pkg::CFG_TARGET_TYPE) begin
            want_type = data[7:0];
        end else if (idx == tlvd_pkg::CFG_JOIN_LIMIT) begin
            capacity = data;
        end
        cfg_writes++;
    endtask

    // Waits until every expected result has arrived, then lets the pipeline
    // finish any byte that produces nothing.
    task automatic settle();
        while (results_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SettleCycles) @(posedge i_clk);
    endtask

    // Builds one message: mostly well-formed records with random content, some
    // broken ones and some loose noise bytes.
    task automatic queue_message();
        tlvd_pkg::t_in_item req;
        int                 kind;
        int                 nrec;
        int                 rlen;
        int                 len;
        int                 cut;
        kind = $urandom_range(99);
        if (kind < 15) begin
            repeat ($urandom_range(1, 8)) begin
                req.in_byte = 8'($urandom);
                if ($urandom_range(3) == 0) begin
                    req.message_length = 16'($urandom_range(0, 65535));
                end else begin
                    req.message_length = 16'($urandom_range(0, 12));
                end
                message_reqs.push_back(req);
            end
            return;
        end
        message_bytes.delete();
        nrec = $urandom_range(1, 5);
        repeat (nrec) begin
            if ($urandom_range(99) < 60) begin
                message_bytes.push_back(want_type);
            end else begin
                message_bytes.push_back(8'($urandom));
            end
            rlen = ($urandom_range(19) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 6);
            message_bytes.push_back(8'(rlen));
            repeat (rlen) message_bytes.push_back(8'($urandom));
        end
        len = message_bytes.size();
        if (kind < 30) begin
            case ($urandom_range(3))
                0: begin
                    // Cut short at a random byte, so a header can overrun the end.
                    cut = $urandom_range(1, message_bytes.size() - 1);
                    while (message_bytes.size() > cut) begin
                        void'(message_bytes.pop_back());
                    end
                    len = message_bytes.size();
                end
                1: len = $urandom_range(1, message_bytes.size() - 1);
                2: len = message_bytes.size() + $urandom_range(1, 4);
                default: begin
                    message_bytes.push_back(8'($urandom));
                    len = message_bytes.size();
                end
            endcase
        end
        foreach (message_bytes[i]) begin
            req.in_byte = message_bytes[i];
            req.message_length = 16'(len);
            message_reqs.push_back(req);
        end
    endtask

    // One phase of random traffic under one register setting.
    task automatic run_phase(input logic [7:0] tgt, input logic [15:0] cap, input bit poke_spare,
                             input int send_pct, input int recv_pct, input int hold);
        int unsigned start;
        write_register(tlvd_pkg::CFG_TARGET_TYPE, {8'h00, tgt});
        write_register(tlvd_pkg::CFG_JOIN_LIMIT, cap);
        if (poke_spare) begin
            write_register(CfgSpareIndex, 16'($urandom));
        end
        i_cfg_valid <= 1'b0;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        hold_request = hold;
        start = bytes_sent;
        while (bytes_sent - start < PhaseBytes) begin
            queue_message();
            while (message_reqs.size() != 0) begin
                send_request(message_reqs.pop_front(), 1'b0, '0);
            end
        end
        i_in_valid <= 1'b0;
        settle();
    endtask

    // Result side: checks each accepted result, then picks the next ready.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            seen = o_out_data;
            if (results_due.size() == 0) begin
                report_mismatch("result with nothing expected", '0, seen);
            end else begin
                wanted = results_due.pop_front();
                if (seen.byte_valid !== wanted.byte_valid || seen.out_byte !== wanted.out_byte
                        || seen.done_res !== wanted.done_res || seen.status !== wanted.status
                        || seen.total_length !== wanted.total_length) begin
                    report_mismatch("result mismatch", wanted, seen);
                end
                if (wanted.byte_valid) begin
                    values_joined++;
                end
                if (wanted.done_res) begin
                    case (wanted.status)
                        tlvd_pkg::STATUS_FOUND: ends_found++;
                        tlvd_pkg::STATUS_NOT_FOUND: ends_missing++;
                        default: ends_over++;
                    endcase
                end
            end
        end
        if (hold_request > 0) begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            i_out_ready <= 1'b0;
            hold_left--;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycles_run++;
        if (cycles_run >= CycleLimit) begin
            $display("Run stopped at the cycle limit with %0d results outstanding.",
                     results_due.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        repeat (ResetCycles) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed messages under the reset settings (type 0, full capacity).
        // A single byte, and a zero length: both end at once, nothing found.
        directed_table.push_back(dir_row(8'hFF, 16'd1, 1'b1, EndNotFound));
        directed_table.push_back(dir_row(8'h00, 16'd0, 1'b1, EndNotFound));
        // Two matching records joined into one value.
        directed_table.push_back(dir_row(8'h00, 16'd7));
        directed_table.push_back(dir_row(8'h01, 16'd7));
        directed_table.push_back(dir_row(8'h11, 16'd7));
        directed_table.push_back(dir_row(8'h00, 16'd7));
        directed_table.push_back(dir_row(8'h02, 16'd7));
        directed_table.push_back(dir_row(8'h22, 16'd7));
        directed_table.push_back(dir_row(8'h33, 16'd7, 1'b1,
            tlvd_pkg::t_out_item'{1'b1, 8'h33, 1'b1, tlvd_pkg::STATUS_FOUND, 16'd3}));
        // Matching record with an empty value.
        directed_table.push_back(dir_row(8'h00, 16'd2));
        directed_table.push_back(dir_row(8'h00, 16'd2, 1'b1,
            tlvd_pkg::t_out_item'{1'b0, 8'h00, 1'b1, tlvd_pkg::STATUS_FOUND, 16'd0}));
        // A different type after the matched run stops the scan.
        directed_table.push_back(dir_row(8'h00, 16'd6));
        directed_table.push_back(dir_row(8'h01, 16'd6));
        directed_table.push_back(dir_row(8'h77, 16'd6));
        directed_table.push_back(dir_row(8'h05, 16'd6));
        directed_table.push_back(dir_row(8'h01, 16'd6));
        directed_table.push_back(dir_row(8'h88, 16'd6, 1'b1,
            tlvd_pkg::t_out_item'{1'b0, 8'h00, 1'b1, tlvd_pkg::STATUS_FOUND, 16'd1}));
        // Record length running past the message end.
        directed_table.push_back(dir_row(8'h00, 16'd3));
        directed_table.push_back(dir_row(8'hFF, 16'd3));
        directed_table.push_back(dir_row(8'h01, 16'd3, 1'b1, EndNotFound));
        // Lone trailing byte after a skipped empty record.
        directed_table.push_back(dir_row(8'h07, 16'd3));
        directed_table.push_back(dir_row(8'h00, 16'd3));
        directed_table.push_back(dir_row(8'h00, 16'd3, 1'b1, EndNotFound));
        // Longest message length, then a length that shrinks below the position.
        directed_table.push_back(dir_row(8'h00, 16'hFFFF));
        directed_table.push_back(dir_row(8'hFF, 16'd1, 1'b1, EndNotFound));

        send_idle_pct = 27;
        recv_idle_pct = 75;
        foreach (directed_table[i]) begin
            send_request(directed_table[i].req, directed_table[i].typed, directed_table[i].res);
        end
        i_in_valid <= 1'b0;
        settle();

        // Random traffic: small capacity, then none, then full with a long stall.
        run_phase(8'hFF, 16'd5, 1'b0, 27, 75, 0);
        run_phase(8'($urandom), 16'd0, 1'b1, 75, 27, 0);
        run_phase(8'h00, 16'hFFFF, 1'b0, 0, 0, HoldCycles);

        if (results_due.size() != 0) begin
            mismatches += results_due.size();
            $display("%0d expected results never arrived.", results_due.size());
        end

        $display("Decoded %0d byte requests over %0d register writes; %0d value bytes joined.",
                 bytes_sent, cfg_writes, values_joined);
        $display("Message ends: %0d found, %0d type absent, %0d over capacity; %0d mismatches.",
                 ends_found, ends_missing, ends_over, mismatches);
        if (mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
